// ===== rtl/sbc_pkg.sv =====
// Shared types, constants and helpers for the swept box collision side block.
package sbc_pkg;

  // Width of a signed gap or penetration between two box edges.
  localparam int GW = 27;
  // Width of a velocity magnitude; the divider remainder is one bit wider.
  localparam int DW = 16;
  localparam int RW = DW + 1;

  typedef enum logic [2:0] {
    SIDE_NONE   = 3'd0,
    SIDE_LEFT   = 3'd1,
    SIDE_RIGHT  = 3'd2,
    SIDE_TOP    = 3'd3,
    SIDE_BOTTOM = 3'd4
  } side_e;

  // Control that travels down the divider chain next to the dividends.
  typedef struct packed {
    logic       ovl;
    side_e      ovl_side;
    logic       none_early;
    logic       vx_pos;
    logic       vy_pos;
    logic       vx_zero;
    logic       vy_zero;
    logic [3:0] neg;
  } ctl_t;

  function automatic logic [GW-2:0] gap_abs(input logic signed [GW-1:0] g);
    logic signed [GW-1:0] m;
    m = g[GW-1] ? -g : g;
    return m[GW-2:0];
  endfunction

endpackage

// ===== rtl/sbc_if.sv =====
// Valid/ready channel interfaces for box pairs and side results.
interface sbc_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] main_x;
  logic signed [23:0] main_y;
  logic        [7:0]  main_size;
  logic signed [15:0] main_vx;
  logic signed [15:0] main_vy;
  logic signed [23:0] other_x;
  logic signed [23:0] other_y;
  logic        [7:0]  other_size;
  logic signed [15:0] other_vx;
  logic signed [15:0] other_vy;

  modport source (
    output valid, main_x, main_y, main_size, main_vx, main_vy,
    output other_x, other_y, other_size, other_vx, other_vy,
    input  ready
  );
  modport sink (
    input  valid, main_x, main_y, main_size, main_vx, main_vy,
    input  other_x, other_y, other_size, other_vx, other_vy,
    output ready
  );
endinterface

interface sbc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] hit_side;

  modport source (output valid, hit_side, input ready);
  modport sink (input valid, hit_side, output ready);
endinterface

// ===== rtl/swept_box_collision_side.sv =====
// Top level of the swept box collision side block.
// A box pair enters on in_i as one beat: position, size and velocity of the
// first and second square box. For each pair exactly one beat leaves on
// out_o with hit_side: 0 none, 1 left, 2 right, 3 top, 4 bottom of the
// first box. Overlapping boxes report the side of least penetration; other
// pairs are tested along their relative motion over one frame.
// The block is a pipeline: two front stages, a chain of 26 + FRAC_BITS
// divider cells that each resolve one quotient bit of the four entry and
// exit times, and two back stages. A new pair is taken every cycle unless
// the receiver holds ready low with a result waiting; then the whole
// pipeline freezes and in_i.ready drops until that beat is taken. No
// result is lost or repeated. Reset empties every stage; there is no
// configuration and no state carried between pairs.
module swept_box_collision_side #(
  parameter int FRAC_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sbc_in_if.sink           in_i,
  sbc_out_if.source        out_o
);

  localparam int NW = sbc_pkg::GW - 1 + FRAC_BITS;
  localparam int ZW = sbc_pkg::RW + NW;

  logic en;
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  logic                           vld   [NW+1];
  sbc_pkg::ctl_t                  ctl   [NW+1];
  logic [3:0][ZW-1:0]             z     [NW+1];
  logic [sbc_pkg::DW-1:0]         dx    [NW+1];
  logic [sbc_pkg::DW-1:0]         dy    [NW+1];

  sbc_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_i.valid),
    .main_x_i     (in_i.main_x),
    .main_y_i     (in_i.main_y),
    .main_size_i  (in_i.main_size),
    .main_vx_i    (in_i.main_vx),
    .main_vy_i    (in_i.main_vy),
    .other_x_i    (in_i.other_x),
    .other_y_i    (in_i.other_y),
    .other_size_i (in_i.other_size),
    .other_vx_i   (in_i.other_vx),
    .other_vy_i   (in_i.other_vy),
    .valid_o      (vld[0]),
    .ctl_o        (ctl[0]),
    .z_o          (z[0]),
    .dx_o         (dx[0]),
    .dy_o         (dy[0])
  );

  for (genvar i = 0; i < NW; i++) begin : g_cell
    sbc_cell #(.NW(NW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[i]),
      .ctl_i   (ctl[i]),
      .z_i     (z[i]),
      .dx_i    (dx[i]),
      .dy_i    (dy[i]),
      .valid_o (vld[i+1]),
      .ctl_o   (ctl[i+1]),
      .z_o     (z[i+1]),
      .dx_o    (dx[i+1]),
      .dy_o    (dy[i+1])
    );
  end

  sbc_back #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vld[NW]),
    .ctl_i      (ctl[NW]),
    .z_i        (z[NW]),
    .valid_o    (out_o.valid),
    .hit_side_o (out_o.hit_side)
  );

`ifndef NO_ASSERTIONS
  a_side_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.hit_side <= 3'(sbc_pkg::SIDE_BOTTOM)))
    else $error("hit_side carries an unused code");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while the result beat is stalled");

  a_chain_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(vld[0]))
    else $error("divider chain moved during a stall");
`endif

endmodule

// ===== rtl/sbc_front.sv =====
// Front stages: edge penetrations, overlap decision and divider operand setup.
module sbc_front #(
  parameter int FRAC_BITS = 8,
  parameter int NW        = 34
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [23:0]                    main_x_i,
  input  logic signed [23:0]                    main_y_i,
  input  logic        [7:0]                     main_size_i,
  input  logic signed [15:0]                    main_vx_i,
  input  logic signed [15:0]                    main_vy_i,
  input  logic signed [23:0]                    other_x_i,
  input  logic signed [23:0]                    other_y_i,
  input  logic        [7:0]                     other_size_i,
  input  logic signed [15:0]                    other_vx_i,
  input  logic signed [15:0]                    other_vy_i,
  output logic                                  valid_o,
  output sbc_pkg::ctl_t                         ctl_o,
  output logic [3:0][sbc_pkg::RW+NW-1:0]        z_o,
  output logic [sbc_pkg::DW-1:0]                dx_o,
  output logic [sbc_pkg::DW-1:0]                dy_o
);

  localparam int GW = sbc_pkg::GW;

  logic signed [GW-1:0] ax, ay, bx, by, as_s, bs_s;
  logic signed [GW-1:0] pen_l_d, pen_r_d, pen_u_d, pen_d_d;
  logic signed [GW-1:0] pen_l_q, pen_r_q, pen_u_q, pen_d_q;
  logic signed [16:0]   vx_d, vy_d, vx_q, vy_q;
  logic                 v1_q;

  assign ax   = {{(GW-24){main_x_i[23]}}, main_x_i};
  assign ay   = {{(GW-24){main_y_i[23]}}, main_y_i};
  assign bx   = {{(GW-24){other_x_i[23]}}, other_x_i};
  assign by   = {{(GW-24){other_y_i[23]}}, other_y_i};
  assign as_s = signed'({{(GW-8){1'b0}}, main_size_i} << FRAC_BITS);
  assign bs_s = signed'({{(GW-8){1'b0}}, other_size_i} << FRAC_BITS);

  assign pen_r_d = bx + bs_s - ax;
  assign pen_l_d = ax + as_s - bx;
  assign pen_d_d = by + bs_s - ay;
  assign pen_u_d = ay + as_s - by;
  assign vx_d    = {main_vx_i[15], main_vx_i} - {other_vx_i[15], other_vx_i};
  assign vy_d    = {main_vy_i[15], main_vy_i} - {other_vy_i[15], other_vy_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pen_l_q <= pen_l_d;
      pen_r_q <= pen_r_d;
      pen_u_q <= pen_u_d;
      pen_d_q <= pen_d_d;
      vx_q    <= vx_d;
      vy_q    <= vy_d;
    end
  end

  // Second stage: pick the entry and exit gaps and split them into sign and magnitude.
  logic                 vx_zero, vy_zero, vx_pos, vy_pos;
  logic signed [GW-1:0] x_in, x_out, y_in, y_out;
  logic signed [GW-1:0] ox, oy;
  logic signed [16:0]   vx_abs, vy_abs;
  sbc_pkg::ctl_t        ctl_d;
  logic [3:0][sbc_pkg::RW+NW-1:0] z_d;

  assign vx_zero = (vx_q == 17'sd0);
  assign vy_zero = (vy_q == 17'sd0);
  assign vx_pos  = !vx_q[16] && !vx_zero;
  assign vy_pos  = !vy_q[16] && !vy_zero;
  assign x_in    = vx_pos ? -pen_l_q : pen_r_q;
  assign x_out   = vx_pos ? pen_r_q : -pen_l_q;
  assign y_in    = vy_pos ? -pen_u_q : pen_d_q;
  assign y_out   = vy_pos ? pen_d_q : -pen_u_q;
  assign ox      = (pen_l_q < pen_r_q) ? pen_l_q : pen_r_q;
  assign oy      = (pen_u_q < pen_d_q) ? pen_u_q : pen_d_q;
  assign vx_abs  = vx_q[16] ? -vx_q : vx_q;
  assign vy_abs  = vy_q[16] ? -vy_q : vy_q;

  always_comb begin
    ctl_d.ovl = (pen_l_q > 0) && (pen_r_q > 0) && (pen_u_q > 0) && (pen_d_q > 0);
    if (ox < oy) begin
      ctl_d.ovl_side = (pen_l_q < pen_r_q) ? sbc_pkg::SIDE_RIGHT : sbc_pkg::SIDE_LEFT;
    end else begin
      ctl_d.ovl_side = (pen_u_q < pen_d_q) ? sbc_pkg::SIDE_BOTTOM : sbc_pkg::SIDE_TOP;
    end
    ctl_d.none_early = (vx_zero && (pen_l_q <= 0 || pen_r_q <= 0))
                    || (vy_zero && (pen_u_q <= 0 || pen_d_q <= 0));
    ctl_d.vx_pos  = vx_pos;
    ctl_d.vy_pos  = vy_pos;
    ctl_d.vx_zero = vx_zero;
    ctl_d.vy_zero = vy_zero;
    ctl_d.neg[0]  = x_in[GW-1] ^ vx_q[16];
    ctl_d.neg[1]  = x_out[GW-1] ^ vx_q[16];
    ctl_d.neg[2]  = y_in[GW-1] ^ vy_q[16];
    ctl_d.neg[3]  = y_out[GW-1] ^ vy_q[16];
    z_d[0] = {{sbc_pkg::RW{1'b0}}, sbc_pkg::gap_abs(x_in), {FRAC_BITS{1'b0}}};
    z_d[1] = {{sbc_pkg::RW{1'b0}}, sbc_pkg::gap_abs(x_out), {FRAC_BITS{1'b0}}};
    z_d[2] = {{sbc_pkg::RW{1'b0}}, sbc_pkg::gap_abs(y_in), {FRAC_BITS{1'b0}}};
    z_d[3] = {{sbc_pkg::RW{1'b0}}, sbc_pkg::gap_abs(y_out), {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o <= ctl_d;
      z_o   <= z_d;
      dx_o  <= vx_abs[sbc_pkg::DW-1:0];
      dy_o  <= vy_abs[sbc_pkg::DW-1:0];
    end
  end

endmodule

// ===== rtl/sbc_cell.sv =====
// One restoring division step for the four entry and exit time quotients.
module sbc_cell #(
  parameter int NW = 34
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  sbc_pkg::ctl_t                  ctl_i,
  input  logic [3:0][sbc_pkg::RW+NW-1:0] z_i,
  input  logic [sbc_pkg::DW-1:0]         dx_i,
  input  logic [sbc_pkg::DW-1:0]         dy_i,
  output logic                           valid_o,
  output sbc_pkg::ctl_t                  ctl_o,
  output logic [3:0][sbc_pkg::RW+NW-1:0] z_o,
  output logic [sbc_pkg::DW-1:0]         dx_o,
  output logic [sbc_pkg::DW-1:0]         dy_o
);

  localparam int ZW = sbc_pkg::RW + NW;
  localparam int RW = sbc_pkg::RW;

  logic [3:0][ZW-1:0] z_d;

  // The upper RW bits hold the partial remainder, the lower bits the dividend
  // still to be shifted in and the quotient bits already found.
  always_comb begin
    logic [ZW-1:0] t;
    logic [RW-1:0] dv;
    for (int k = 0; k < 4; k++) begin
      t  = z_i[k] << 1;
      dv = (k < 2) ? {1'b0, dx_i} : {1'b0, dy_i};
      if (t[ZW-1 -: RW] >= dv) begin
        t[ZW-1 -: RW] = t[ZW-1 -: RW] - dv;
        t[0] = 1'b1;
      end
      z_d[k] = t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o <= ctl_i;
      z_o   <= z_d;
      dx_o  <= dx_i;
      dy_o  <= dy_i;
    end
  end

endmodule

// ===== rtl/sbc_back.sv =====
// Back stages: signed times, hit window test and the output register.
module sbc_back #(
  parameter int FRAC_BITS = 8,
  parameter int NW        = 34
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  sbc_pkg::ctl_t                  ctl_i,
  input  logic [3:0][sbc_pkg::RW+NW-1:0] z_i,
  output logic                           valid_o,
  output logic [2:0]                     hit_side_o
);

  localparam int TW = NW + 2;
  localparam logic signed [TW-1:0] NoLimitLow  = {2'b11, {NW{1'b0}}};
  localparam logic signed [TW-1:0] NoLimitHigh = {2'b01, {NW{1'b0}}};
  localparam logic signed [TW-1:0] OneT = TW'(1) << FRAC_BITS;

  logic signed [3:0][TW-1:0] t_d;
  logic signed [TW-1:0]      t_q [4];
  sbc_pkg::ctl_t             ctl_q;
  logic                      va_q;

  always_comb begin
    logic signed [TW-1:0] m;
    for (int k = 0; k < 4; k++) begin
      m = signed'({2'b00, z_i[k][NW-1:0]});
      t_d[k] = ctl_i.neg[k] ? -m : m;
    end
    if (ctl_i.vx_zero) begin
      t_d[0] = NoLimitLow;
      t_d[1] = NoLimitHigh;
    end
    if (ctl_i.vy_zero) begin
      t_d[2] = NoLimitLow;
      t_d[3] = NoLimitHigh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_i;
      for (int k = 0; k < 4; k++) begin
        t_q[k] <= t_d[k];
      end
    end
  end

  // The latest entry is after the earliest exit exactly when some entry is
  // after some exit, so no max or min is needed before the window test.
  logic           late, early, after_frame, x_first;
  sbc_pkg::side_e side_d;

  assign late        = (t_q[0] > t_q[1]) || (t_q[0] > t_q[3])
                    || (t_q[2] > t_q[1]) || (t_q[2] > t_q[3]);
  assign early       = (t_q[0] < 0) && (t_q[2] < 0);
  assign after_frame = (t_q[0] > OneT) || (t_q[2] > OneT);
  assign x_first     = t_q[0] > t_q[2];

  always_comb begin
    if (ctl_q.ovl) begin
      side_d = ctl_q.ovl_side;
    end else if (ctl_q.none_early || late || early || after_frame) begin
      side_d = sbc_pkg::SIDE_NONE;
    end else if (x_first) begin
      side_d = ctl_q.vx_pos ? sbc_pkg::SIDE_RIGHT : sbc_pkg::SIDE_LEFT;
    end else begin
      side_d = ctl_q.vy_pos ? sbc_pkg::SIDE_BOTTOM : sbc_pkg::SIDE_TOP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_side_o <= side_d;
    end
  end

endmodule

// ===== dv/sbc_scoreboard.sv =====
// Scoreboard class that predicts and checks the hit side of each box pair.
`timescale 1ns / 1ps

class sbc_scoreboard;
  int unsigned frac_bits;
  sbc_pkg::side_e pending_sides[$];
  int unsigned errors;

  function new(int unsigned fb);
    frac_bits = fb;
    errors    = 0;
  endfunction

  // Exact prediction at 64 bits; nothing here can overflow.
  function sbc_pkg::side_e predict_side(
      longint ax, longint ay, longint asz, longint avx, longint avy,
      longint bx, longint by, longint bsz, longint bvx, longint bvy);
    longint one, as_f, bs_f, pen_r, pen_l, pen_d, pen_u, ox, oy;
    longint vx, vy, x_in, x_out, y_in, y_out;
    longint tx_in, tx_out, ty_in, ty_out, t_in, t_out;
    one   = longint'(1) << frac_bits;
    as_f  = asz * one;
    bs_f  = bsz * one;
    pen_r = (bx + bs_f) - ax;
    pen_l = (ax + as_f) - bx;
    pen_d = (by + bs_f) - ay;
    pen_u = (ay + as_f) - by;
    if (pen_l > 0 && pen_r > 0 && pen_u > 0 && pen_d > 0) begin
      ox = (pen_l < pen_r) ? pen_l : pen_r;
      oy = (pen_u < pen_d) ? pen_u : pen_d;
      if (ox < oy) return (pen_l < pen_r) ? sbc_pkg::SIDE_RIGHT : sbc_pkg::SIDE_LEFT;
      return (pen_u < pen_d) ? sbc_pkg::SIDE_BOTTOM : sbc_pkg::SIDE_TOP;
    end
    vx = avx - bvx;
    vy = avy - bvy;
    if (vx > 0) begin
      x_in = bx - (ax + as_f); x_out = (bx + bs_f) - ax;
    end else begin
      x_in = (bx + bs_f) - ax; x_out = bx - (ax + as_f);
    end
    if (vy > 0) begin
      y_in = by - (ay + as_f); y_out = (by + bs_f) - ay;
    end else begin
      y_in = (by + bs_f) - ay; y_out = by - (ay + as_f);
    end
    if (vx == 0) begin
      if (ax + as_f <= bx || ax >= bx + bs_f) return sbc_pkg::SIDE_NONE;
      tx_in  = -(longint'(1) << 62);
      tx_out = longint'(1) << 62;
    end else begin
      // SystemVerilog signed division truncates toward zero.
      tx_in  = (x_in * one) / vx;
      tx_out = (x_out * one) / vx;
    end
    if (vy == 0) begin
      if (ay + as_f <= by || ay >= by + bs_f) return sbc_pkg::SIDE_NONE;
      ty_in  = -(longint'(1) << 62);
      ty_out = longint'(1) << 62;
    end else begin
      ty_in  = (y_in * one) / vy;
      ty_out = (y_out * one) / vy;
    end
    t_in  = (tx_in > ty_in) ? tx_in : ty_in;
    t_out = (tx_out < ty_out) ? tx_out : ty_out;
    if (t_in > t_out || t_in < 0 || t_in > one) return sbc_pkg::SIDE_NONE;
    if (tx_in > ty_in) return (vx > 0) ? sbc_pkg::SIDE_RIGHT : sbc_pkg::SIDE_LEFT;
    return (vy > 0) ? sbc_pkg::SIDE_BOTTOM : sbc_pkg::SIDE_TOP;
  endfunction

  function void note_pair(
      logic signed [23:0] ax, logic signed [23:0] ay, logic [7:0] asz,
      logic signed [15:0] avx, logic signed [15:0] avy,
      logic signed [23:0] bx, logic signed [23:0] by, logic [7:0] bsz,
      logic signed [15:0] bvx, logic signed [15:0] bvy);
    pending_sides.push_back(predict_side(ax, ay, {56'd0, asz}, avx, avy,
                                         bx, by, {56'd0, bsz}, bvx, bvy));
  endfunction

  function void check_side(logic [2:0] got);
    sbc_pkg::side_e want;
    if (pending_sides.size() == 0) begin
      $display("%0t: unexpected hit_side beat, actual %0d", $time, got);
      errors++;
      return;
    end
    want = pending_sides.pop_front();
    if (got !== want) begin
      $display("%0t: hit_side mismatch, expected %0d actual %0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

// ===== dv/testbench.sv =====
// Top module that streams box pairs through the collision block and checks sides.
`timescale 1ns / 1ps

module testbench;
  localparam int FRAC_BITS = 8;
  localparam int LATENCY   = FRAC_BITS + 30;
  localparam int WATCHDOG  = 20000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sbc_in_if  pair_ch ();
  sbc_out_if side_ch ();

  swept_box_collision_side #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pair_ch.sink),
    .out_o (side_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sbc_scoreboard board = new(FRAC_BITS);

  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  bit          hold_off       = 1'b0;
  int unsigned quiet_cycles   = 0;

  logic signed [23:0] ax, ay, bx, by;
  logic        [7:0]  asz, bsz;
  logic signed [15:0] avx, avy, bvx, bvy;

  initial begin
    pair_ch.valid      = 1'b0;
    pair_ch.main_x     = '0;
    pair_ch.main_y     = '0;
    pair_ch.main_size  = '0;
    pair_ch.main_vx    = '0;
    pair_ch.main_vy    = '0;
    pair_ch.other_x    = '0;
    pair_ch.other_y    = '0;
    pair_ch.other_size = '0;
    pair_ch.other_vx   = '0;
    pair_ch.other_vy   = '0;
    side_ch.ready      = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off window when requested.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      side_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
      if (side_ch.valid && side_ch.ready) board.check_side(side_ch.hit_side);
      if ((side_ch.valid && side_ch.ready) || (pair_ch.valid && pair_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sends one pair and returns after the beat is accepted.
  task automatic send_pair();
    // Valid stays high after a beat and drops only for idle cycles.
    while ($urandom_range(99) < send_idle_pct) begin
      pair_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pair_ch.valid      <= 1'b1;
    pair_ch.main_x     <= ax;
    pair_ch.main_y     <= ay;
    pair_ch.main_size  <= asz;
    pair_ch.main_vx    <= avx;
    pair_ch.main_vy    <= avy;
    pair_ch.other_x    <= bx;
    pair_ch.other_y    <= by;
    pair_ch.other_size <= bsz;
    pair_ch.other_vx   <= bvx;
    pair_ch.other_vy   <= bvy;
    @(posedge clk_i);
    while (!pair_ch.ready) @(posedge clk_i);
    board.note_pair(ax, ay, asz, avx, avy, bx, by, bsz, bvx, bvy);
  endtask

  // Pairs that sit near each other so overlaps and swept hits are common.
  task automatic make_near_pair();
    int unsigned span;
    span = 1 << $urandom_range(16, 8);
    asz  = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(16));
    bsz  = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(16));
    ax   = 24'($urandom);
    ay   = 24'($urandom);
    bx   = ax + 24'(int'($urandom_range(2 * span)) - int'(span));
    by   = ay + 24'(int'($urandom_range(2 * span)) - int'(span));
    avx  = $urandom_range(3) == 0 ? 16'($urandom) : 16'(int'($urandom_range(2048)) - 1024);
    avy  = $urandom_range(3) == 0 ? 16'($urandom) : 16'(int'($urandom_range(2048)) - 1024);
    bvx  = $urandom_range(4) == 0 ? 16'd0 : 16'($urandom);
    bvy  = $urandom_range(4) == 0 ? 16'd0 : 16'($urandom);
    if ($urandom_range(5) == 0) bvx = avx;
    if ($urandom_range(5) == 0) bvy = avy;
  endtask

  task automatic make_noise_pair();
    ax  = 24'($urandom); ay  = 24'($urandom); asz = 8'($urandom);
    bx  = 24'($urandom); by  = 24'($urandom); bsz = 8'($urandom);
    avx = 16'($urandom); avy = 16'($urandom);
    bvx = 16'($urandom); bvy = 16'($urandom);
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) begin
      if ($urandom_range(9) < 8) make_near_pair();
      else make_noise_pair();
      send_pair();
    end
    pair_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic directed_pair(
      int x0, int y0, int s0, int vx0, int vy0,
      int x1, int y1, int s1, int vx1, int vy1);
    ax = 24'(x0); ay = 24'(y0); asz = 8'(s0); avx = 16'(vx0); avy = 16'(vy0);
    bx = 24'(x1); by = 24'(y1); bsz = 8'(s1); bvx = 16'(vx1); bvy = 16'(vy1);
    send_pair();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Overlaps: left, right, top, bottom and the tie cases.
    directed_pair(0, 0, 10, 0, 0, 2304, 0, 10, 0, 0);
    directed_pair(2304, 0, 10, 0, 0, 0, 0, 10, 0, 0);
    directed_pair(0, 0, 10, 0, 0, 0, 2304, 10, 0, 0);
    directed_pair(0, 2304, 10, 0, 0, 0, 0, 10, 0, 0);
    directed_pair(0, 0, 10, 0, 0, 0, 0, 10, 0, 0);
    directed_pair(0, 0, 10, 0, 0, 1280, 1280, 10, 0, 0);
    // Swept hits from each direction, one of them with equal entry times.
    directed_pair(0, 0, 4, 512, 0, 1280, 0, 4, 0, 0);
    directed_pair(1280, 0, 4, -512, 0, 0, 0, 4, 0, 0);
    directed_pair(0, 0, 4, 0, 512, 0, 1280, 4, 0, 0);
    directed_pair(0, 1280, 4, 0, -512, 0, 0, 4, 0, 0);
    directed_pair(0, 0, 4, 512, 512, 1280, 1280, 4, 0, 0);
    // Zero relative velocity, apart and aligned; exact touching edges.
    directed_pair(0, 0, 4, 100, 0, 0, 5000, 4, 100, 0);
    directed_pair(0, 0, 4, 100, 100, 5000, 0, 4, 100, 100);
    directed_pair(0, 0, 4, 0, 0, 1024, 0, 4, 0, 0);
    // Zero sizes and field extremes.
    directed_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    directed_pair(0, 0, 0, 256, 0, 128, 0, 0, 0, 0);
    directed_pair(-8388608, -8388608, 255, 32767, 32767,
                  8388607, 8388607, 255, -32768, -32768);
    directed_pair(8388607, 8388607, 255, -32768, -32768,
                  -8388608, -8388608, 255, 32767, 32767);
    directed_pair(-1, -1, 255, -1, -1, -1, -1, 255, -1, -1);
    directed_pair(0, 0, 255, 32767, -32768, 65280, 0, 255, -32768, 32767);

    run_random(200);
    send_idle_pct = 66; run_random(200);
    send_idle_pct = 0;  stall_pct = 66; run_random(200);
    send_idle_pct = 25; stall_pct = 25; run_random(200);

    // Long receiver hold-off while pairs keep coming, so the input stalls.
    send_idle_pct = 0; stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (3 * LATENCY) @(posedge clk_i);
        hold_off = 1'b0;
      end
      run_random(100);
    join

    while (board.pending_sides.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending_sides.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== swept_box_collision_side.f =====
rtl/sbc_pkg.sv
rtl/sbc_if.sv
rtl/sbc_front.sv
rtl/sbc_cell.sv
rtl/sbc_back.sv
rtl/swept_box_collision_side.sv
dv/sbc_scoreboard.sv
dv/testbench.sv
